FILE: rtl/grq_pkg.sv
// ----------------------------------------------------------------------------
// grq_pkg
// Shared widths, codes and controller/datapath signal groups for the
// graph reachability query block.
// ----------------------------------------------------------------------------
package grq_pkg;

    localparam int NODE_W            = 4;
    localparam int COUNT_W           = 5;
    localparam int MAX_NODES_DEFAULT = 16;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

    localparam logic REQ_ADD_EDGE = 1'b0;
    localparam logic REQ_QUERY    = 1'b1;

    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic edge_wr;
        logic start_query;
        logic expand;
        logic load_rsp;
    } grq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic req_valid;
        logic req_err;
        logic req_is_add;
        logic nodes_equal;
        logic next_empty;
        logic out_free;
    } grq_sts_t;

endpackage

FILE: rtl/grq_intf.sv
// ----------------------------------------------------------------------------
// grq_intf
// Handshake channels of the graph reachability query block: request,
// response and node count write.
// ----------------------------------------------------------------------------
interface grq_req_if import grq_pkg::*;;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;

    modport source (output valid, output req_type, output node_a, output node_b,
                    input ready);
    modport sink   (input valid, input req_type, input node_a, input node_b,
                    output ready);
endinterface

interface grq_rsp_if import grq_pkg::*;;
    logic valid;
    logic ready;
    logic status;
    logic path_found;

    modport source (output valid, output status, output path_found, input ready);
    modport sink   (input valid, input status, input path_found, output ready);
endinterface

interface grq_cfg_if import grq_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] node_count;

    modport source (output valid, output node_count, input ready);
    modport sink   (input valid, input node_count, output ready);
endinterface

FILE: rtl/grq_datapath.sv
// ----------------------------------------------------------------------------
// grq_datapath
// Adjacency matrix, node count register, request latch, reached/frontier
// sets with one-round expansion, and the response register.
// ----------------------------------------------------------------------------
module grq_datapath import grq_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    grq_req_if.sink           req,
    grq_rsp_if.source         rsp,
    grq_cfg_if.sink           cfg,
    input  grq_cmd_t          cmd,
    output grq_sts_t          sts
);

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    logic [COUNT_W-1:0]   node_count_reg;
    logic                 kind_reg;
    logic [NODE_W-1:0]    a_reg;
    logic [NODE_W-1:0]    b_reg;
    logic [MAX_NODES-1:0] adj_reg [MAX_NODES];
    logic [MAX_NODES-1:0] reached_reg;
    logic [MAX_NODES-1:0] frontier_reg;
    logic                 out_valid_reg;
    logic                 out_status_reg;
    logic                 out_found_reg;

    logic [CMP_W-1:0]     count_ext;
    logic [CMP_W-1:0]     eff_count;
    logic [MAX_NODES-1:0] active_mask;
    logic [MAX_NODES-1:0] start_set;
    logic [MAX_NODES-1:0] next_set;
    logic [IDX_W-1:0]     a_idx;
    logic [IDX_W-1:0]     b_idx;
    logic                 req_err;
    logic                 found;
    logic                 accept;
    logic                 sym_ok;

    assign accept    = req.valid && cmd.in_ready;
    assign req.ready = cmd.in_ready;
    assign cfg.ready = 1'b1;

    assign count_ext = CMP_W'(node_count_reg);
    assign eff_count = (count_ext > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES) : count_ext;
    assign req_err   = (CMP_W'(a_reg) >= eff_count) || (CMP_W'(b_reg) >= eff_count);
    assign a_idx     = IDX_W'(a_reg);
    assign b_idx     = IDX_W'(b_reg);

    always_comb
    begin
        active_mask = '0;
        start_set   = '0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            active_mask[i] = (CMP_W'(i) < eff_count);
        end
        start_set[a_idx] = 1'b1;
    end

    // one expansion round: union of the rows of all frontier nodes
    always_comb
    begin
        next_set = '0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            if (frontier_reg[i])
            begin
                next_set = next_set | adj_reg[i];
            end
        end
        next_set = next_set & active_mask & ~reached_reg;
    end

    assign found = !req_err && (kind_reg == REQ_QUERY)
                   && ((a_reg == b_reg) || reached_reg[b_idx]);

    assign sts.req_valid   = req.valid;
    assign sts.req_err     = req_err;
    assign sts.req_is_add  = (kind_reg == REQ_ADD_EDGE);
    assign sts.nodes_equal = (a_reg == b_reg);
    assign sts.next_empty  = (next_set == '0);
    assign sts.out_free    = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= COUNT_RESET;
        end
        else if (cfg.valid)
        begin
            node_count_reg <= cfg.node_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= req.req_type;
            a_reg    <= req.node_a;
            b_reg    <= req.node_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_NODES; i++)
            begin
                adj_reg[i] <= '0;
            end
        end
        else if (cmd.edge_wr)
        begin
            adj_reg[a_idx][b_idx] <= 1'b1;
            adj_reg[b_idx][a_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reached_reg  <= '0;
            frontier_reg <= '0;
        end
        else if (cmd.start_query)
        begin
            reached_reg  <= start_set;
            frontier_reg <= start_set;
        end
        else if (cmd.expand)
        begin
            reached_reg  <= reached_reg | next_set;
            frontier_reg <= next_set;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_rsp)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_rsp)
        begin
            out_status_reg <= req_err ? STATUS_ERROR : STATUS_DONE;
            out_found_reg  <= found;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.path_found = out_found_reg;

    always_comb
    begin
        sym_ok = 1'b1;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            for (int j = 0; j < MAX_NODES; j++)
            begin
                if (adj_reg[i][j] != adj_reg[j][i])
                begin
                    sym_ok = 1'b0;
                end
            end
        end
    end

    a_frontier_in_reached: assert property (@(posedge clk) disable iff (!rst_n)
        (frontier_reg & ~reached_reg) == '0)
        else $error("frontier holds a node outside the reached set");

    a_adj_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
        sym_ok)
        else $error("adjacency matrix lost symmetry");

    a_found_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_status_reg && out_found_reg))
        else $error("path reported together with an error status");

    a_reached_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.expand |=> (reached_reg & $past(reached_reg)) == $past(reached_reg))
        else $error("reached set lost a node during expansion");

endmodule

FILE: rtl/grq_ctrl.sv
// ----------------------------------------------------------------------------
// grq_ctrl
// Request sequencer: accept, decode, frontier expansion rounds, response.
// ----------------------------------------------------------------------------
module grq_ctrl import grq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  grq_sts_t sts,
    output grq_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_EXPAND = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.req_err || sts.nodes_equal || sts.req_is_add)
                begin
                    cmd.edge_wr = !sts.req_err && sts.req_is_add;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.start_query = 1'b1;
                    state_next      = S_EXPAND;
                end
            end
            S_EXPAND:
            begin
                cmd.expand = 1'b1;
                if (sts.next_empty)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_rsp = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_err_skips_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECODE && sts.req_err) |=> state_reg == S_DONE)
        else $error("out-of-range request entered the search");

endmodule

FILE: rtl/graph_reachability_query_top.sv
// Flow: edge add, out-of-range request or start equal to end: decode, then
//   the response register is loaded; path query: decode, R frontier rounds
//   (R from 1 to the effective node count), then the response register.
// A new request is taken only in idle, once the previous response is loaded;
//   the expansion loop runs one frontier round per cycle over the matrix.
// Reset: asynchronous, clears the matrix and sets node_count to 16 at once.
// ----------------------------------------------------------------------------
// graph_reachability_query_top
// Undirected graph held as an adjacency bit matrix; answers add-edge and
// path-exists requests, one response beat per request.
// ----------------------------------------------------------------------------
module graph_reachability_query_top import grq_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    grq_req_if.sink   req,
    grq_rsp_if.source rsp,
    grq_cfg_if.sink   cfg
);

    grq_cmd_t cmd;
    grq_sts_t sts;

    grq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    grq_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

FILE: tb/sv/grq_reach_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grq_reach_checker
// Watches the request, response and node count channels of the graph
// reachability block. Keeps its own adjacency matrix and node count, predicts
// one response per request beat and compares each response beat in order.
// ----------------------------------------------------------------------------
module grq_reach_checker import grq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    grq_req_if   req,
    grq_rsp_if   rsp,
    grq_cfg_if   cfg,
    output int   mismatches,
    output int   outstanding
);

    localparam int MAX_NODES    = MAX_NODES_DEFAULT;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic status;
        logic path_found;
    } reach_result_t;

    logic [MAX_NODES-1:0] adj_rows [MAX_NODES];
    logic [MAX_NODES-1:0] reached_nodes;
    logic [MAX_NODES-1:0] frontier_nodes;
    logic [COUNT_W-1:0]   node_count;
    reach_result_t        expected_rsp_q [$];
    int                   error_count = 0;

    function automatic reach_result_t predict_reach(logic kind, logic [NODE_W-1:0] a,
                                                    logic [NODE_W-1:0] b);
        int                   n;
        logic [MAX_NODES-1:0] live_mask;
        logic [MAX_NODES-1:0] next_nodes;
        reach_result_t        r;
        n = (node_count > MAX_NODES) ? MAX_NODES : int'(node_count);
        live_mask = '0;
        for (int i = 0; i < n; i++)
        begin
            live_mask[i] = 1'b1;
        end
        r.status     = STATUS_DONE;
        r.path_found = 1'b0;
        if (int'(a) >= n || int'(b) >= n)
        begin
            r.status = STATUS_ERROR;
        end
        else if (kind == REQ_ADD_EDGE)
        begin
            adj_rows[a][b] = 1'b1;
            adj_rows[b][a] = 1'b1;
        end
        else if (a == b)
        begin
            r.path_found = 1'b1;
        end
        else
        begin
            reached_nodes  = '0;
            reached_nodes[a] = 1'b1;
            frontier_nodes = reached_nodes;
            while (frontier_nodes != '0)
            begin
                next_nodes = '0;
                for (int i = 0; i < n; i++)
                begin
                    if (frontier_nodes[i])
                        next_nodes |= adj_rows[i];
                end
                // nodes at or above the live count are cut off
                next_nodes     &= live_mask & ~reached_nodes;
                reached_nodes  |= next_nodes;
                frontier_nodes  = next_nodes;
            end
            r.path_found = reached_nodes[b];
        end
        return r;
    endfunction

    always @(posedge clk)
    begin : monitor
        reach_result_t got;
        reach_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_NODES; i++)
            begin
                adj_rows[i] = '0;
            end
            reached_nodes  = '0;
            frontier_nodes = '0;
            node_count     = COUNT_RESET;
            expected_rsp_q.delete();
        end
        else
        begin
            // response first: a beat at this edge belongs to an older request
            if (rsp.valid && rsp.ready)
            begin
                got.status     = rsp.status;
                got.path_found = rsp.path_found;
                if (expected_rsp_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: response beat with nothing pending: status %b path_found %b",
                                 $realtime, got.status, got.path_found);
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (got.status !== want.status || got.path_found !== want.path_found)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("%0t: mismatch: status exp %b got %b, path_found exp %b got %b",
                                     $realtime, want.status, got.status,
                                     want.path_found, got.path_found);
                    end
                end
            end
            if (req.valid && req.ready)
                expected_rsp_q.push_back(predict_reach(req.req_type, req.node_a, req.node_b));
            if (cfg.valid && cfg.ready)
                node_count = cfg.node_count;
        end
        mismatches  <= error_count;
        outstanding <= expected_rsp_q.size();
    end

endmodule

FILE: tb/sv/graph_reachability_query_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_reachability_query_top_test
// Drives edge adds and path queries into the graph reachability block over a
// series of node counts and idle patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module graph_reachability_query_top_test import grq_pkg::*;;

    localparam int MAX_NODES      = MAX_NODES_DEFAULT;
    localparam int PHASES         = 14;
    localparam int PHASE_ITEMS    = 100;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 2000;

    // node counts of the random phases; above-max values clamp to 16
    localparam logic [COUNT_W-1:0] PHASE_COUNTS [0:PHASES-1] = '{
        5'd12, 5'd1, 5'd31, 5'd0, 5'd9, 5'd4, 5'd17,
        5'd15, 5'd2, 5'd8, 5'd13, 5'd16, 5'd5, 5'd16
    };

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   send_idle_pct = 0;
    int   rsp_stall_pct = 0;
    int   live_count    = MAX_NODES;

    grq_req_if req ();
    grq_rsp_if rsp ();
    grq_cfg_if cfg ();

    graph_reachability_query_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    grq_reach_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg         (cfg),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp.ready <= rst_n && ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
                (cfg.valid && cfg.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_request(logic kind, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
        req.valid    <= 1'b1;
        req.req_type <= kind;
        req.node_a   <= a;
        req.node_b   <= b;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_node_count(logic [COUNT_W-1:0] value);
        req.valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);
        cfg.valid      <= 1'b1;
        cfg.node_count <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid  <= 1'b0;
        live_count = (value > MAX_NODES) ? MAX_NODES : int'(value);
    endtask

    // one random request; edges are rare and never join the two halves of
    // the node range, so cut-off and long-chain answers stay reachable
    task automatic send_random_item();
        int               roll;
        int               k;
        int               n;
        logic             kind;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        n    = live_count;
        roll = $urandom_range(99);
        if (n == 0 || (n < MAX_NODES && roll < 10))
        begin
            kind = 1'($urandom_range(1));
            a    = NODE_W'($urandom_range(MAX_NODES - 1));
            b    = NODE_W'($urandom_range(MAX_NODES - 1));
            if (n > 0)
            begin
                if ($urandom_range(1))
                    a = NODE_W'($urandom_range(MAX_NODES - 1, n));
                else
                    b = NODE_W'($urandom_range(MAX_NODES - 1, n));
            end
        end
        else if (roll < 17)
        begin
            kind = REQ_ADD_EDGE;
            k    = $urandom_range(9);
            if (n < 2 || k == 9)
            begin
                a = NODE_W'($urandom_range(n - 1));
                b = a;
            end
            else if (k < 7)
            begin
                k = $urandom_range(n - 2);
                if (k == MAX_NODES / 2 - 1)
                    k--;
                a = NODE_W'(k);
                b = NODE_W'(k + 1);
            end
            else
            begin
                a = NODE_W'($urandom_range(n - 1));
                if (a < MAX_NODES / 2)
                    b = NODE_W'($urandom_range((n > MAX_NODES / 2) ? MAX_NODES / 2 - 1
                                                                   : n - 1));
                else
                    b = NODE_W'($urandom_range(n - 1, MAX_NODES / 2));
            end
        end
        else
        begin
            kind = REQ_QUERY;
            a    = NODE_W'($urandom_range(n - 1));
            b    = (roll < 22) ? a : NODE_W'($urandom_range(n - 1));
        end
        send_request(kind, a, b);
    endtask

    initial
    begin : stimulus
        rst_n          = 1'b0;
        req.valid      <= 1'b0;
        req.req_type   <= REQ_ADD_EDGE;
        req.node_a     <= '0;
        req.node_b     <= '0;
        cfg.valid      <= 1'b0;
        cfg.node_count <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty graph, start equals end, self loop, long way round
        send_request(REQ_QUERY,    4'd3,  4'd3);
        send_request(REQ_QUERY,    4'd0,  4'd15);
        send_request(REQ_ADD_EDGE, 4'd0,  4'd15);
        send_request(REQ_QUERY,    4'd15, 4'd0);
        send_request(REQ_ADD_EDGE, 4'd5,  4'd5);
        send_request(REQ_QUERY,    4'd5,  4'd6);
        send_request(REQ_ADD_EDGE, 4'd1,  4'd2);
        send_request(REQ_ADD_EDGE, 4'd2,  4'd3);
        send_request(REQ_QUERY,    4'd3,  4'd1);
        send_request(REQ_ADD_EDGE, 4'd8,  4'd9);
        send_request(REQ_ADD_EDGE, 4'd9,  4'd15);
        send_request(REQ_QUERY,    4'd1,  4'd8);
        send_request(REQ_ADD_EDGE, 4'd0,  4'd1);
        send_request(REQ_QUERY,    4'd3,  4'd8);
        // count lowered below stored edges: out-of-range nodes and cut edges
        write_node_count(5'd4);
        send_request(REQ_QUERY,    4'd0,  4'd3);
        send_request(REQ_QUERY,    4'd0,  4'd15);
        send_request(REQ_ADD_EDGE, 4'd4,  4'd0);
        send_request(REQ_QUERY,    4'd2,  4'd4);
        send_request(REQ_ADD_EDGE, 4'd3,  4'd3);
        send_request(REQ_QUERY,    4'd3,  4'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            write_node_count(PHASE_COUNTS[p]);
            case (p % 4)
                0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1:       begin send_idle_pct = 67; rsp_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  rsp_stall_pct = 67; end
                default: begin send_idle_pct = 16; rsp_stall_pct = 16; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random_item();
        end

        req.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
